// File: sv/bfc_pkg.sv
// Shared types and constants for the find-first-clear bit map allocator.
package bfc_pkg;

   localparam int OP_W = 3;
   localparam int IDX_W = 10;
   localparam int FI_W = 10;
   localparam int ST_W = 2;
   localparam int BIU_W = 11;
   localparam int BIU_RESET = 1024;

   localparam logic [OP_W-1:0] OP_READ = 3'd0;
   localparam logic [OP_W-1:0] OP_SET = 3'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 3'd2;
   localparam logic [OP_W-1:0] OP_CLEAR_ALL = 3'd3;
   localparam logic [OP_W-1:0] OP_FIND = 3'd4;

   localparam logic [ST_W-1:0] STAT_OK = 2'd0;
   localparam logic [ST_W-1:0] STAT_RANGE = 2'd1;
   localparam logic [ST_W-1:0] STAT_NONE = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ISSUE,
      ST_MODIFY,
      ST_SCAN,
      ST_ENCODE
   } state_type;

endpackage

// File: sv/bfc_map_ram.sv
// Single-port-write, registered-read word memory holding the bit map.
module bfc_map_ram
   import bfc_pkg::*;
#(
   parameter int DEPTH = 32,
   parameter int WIDTH = 32,
   parameter int AW = 5
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/bfc_zero_find.sv
// Lowest-zero position encoder for one map word.
module bfc_zero_find
   import bfc_pkg::*;
#(
   parameter int WORD_BITS = 32,
   parameter int PW = 5
) (
   input  logic [WORD_BITS-1:0] word,
   output logic [PW-1:0]        pos
);

   logic [WORD_BITS-1:0] inv;
   logic [WORD_BITS-1:0] low;

   assign inv = ~word;
   assign low = inv & (~inv + WORD_BITS'(1));

   always_comb begin
      pos = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (low[i]) begin
            pos = pos | PW'(i);
         end
      end
   end

endmodule

// File: sv/bitmap_allocator_find_first_clear_unit.sv
// Top level: bit map allocator with a find-first-clear word scan.
// Read, set, clear: decode at accept, map word read, modify, then the registered result strobe.
// Find: scans up to MAX_BITS/WORD_BITS map words (rounded up), one map word read per cycle.
// Clear all: writes every map word, one word written per cycle.
// Out of range and unused ops: result strobe in the cycle after accept. One request at a time.
// Reset: synchronous; clears the whole map with busy high.
module bitmap_allocator_find_first_clear_unit
   import bfc_pkg::*;
#(
   parameter int MAX_BITS = 1024,
   parameter int WORD_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [OP_W-1:0]  req_op,
   input  logic [IDX_W-1:0] req_bit_index,
   output logic             rsp_strobe,
   output logic             rsp_bit_value,
   output logic [FI_W-1:0]  rsp_found_index,
   output logic [ST_W-1:0]  rsp_status,
   input  logic             csr_write_enable,
   input  logic [BIU_W-1:0] csr_write_data
);

   localparam int NUM_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int PW = $clog2(WORD_BITS);
   localparam int CNT_W = $clog2(MAX_BITS + 1);
   localparam int CW0 = (CNT_W > BIU_W) ? CNT_W : BIU_W;
   localparam int SPAN_W = $clog2(NUM_WORDS * WORD_BITS) + 1;
   localparam int KW = (SPAN_W > CW0) ? SPAN_W : CW0;
   localparam int SHIFT = IDX_W + PW;
   localparam int RECIP = ((1 << SHIFT) + WORD_BITS - 1) / WORD_BITS;
   localparam int RW = IDX_W + 2;
   localparam int PRW = IDX_W + RW;
   localparam int RESET_LIVE = (MAX_BITS < BIU_RESET) ? MAX_BITS : BIU_RESET;

   state_type state_ff, state_in;
   logic [OP_W-1:0]  op_ff, op_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [AW-1:0]    word_ff, word_in;
   logic [PW-1:0]    pos_ff, pos_in;
   logic [AW-1:0]    scan_ff, scan_in;
   logic             clr_rsp_ff, clr_rsp_in;
   logic [WORD_BITS-1:0] hit_word_ff, hit_word_in;
   logic [CNT_W-1:0] live_ff, live_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_bit_value_ff, rsp_bit_value_in;
   logic [FI_W-1:0]  rsp_found_ff, rsp_found_in;
   logic [ST_W-1:0]  rsp_status_ff, rsp_status_in;

   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic [WORD_BITS-1:0] rd_data;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [WORD_BITS-1:0] wr_data;

   logic [PRW-1:0]       qprod;
   logic [AW-1:0]        mult_src;
   logic [KW-1:0]        base;
   logic [PW-1:0]        zpos;
   logic [KW-1:0]        kval;
   logic                 in_range;
   logic [WORD_BITS-1:0] onehot;

   bfc_map_ram #(
      .DEPTH (NUM_WORDS),
      .WIDTH (WORD_BITS),
      .AW    (AW)
   ) u_map_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   bfc_zero_find #(
      .WORD_BITS (WORD_BITS),
      .PW        (PW)
   ) u_zero_find (
      .word (hit_word_ff),
      .pos  (zpos)
   );

   assign qprod = PRW'(req_bit_index) * PRW'(RECIP);
   assign in_range = KW'(req_bit_index) < KW'(live_ff);
   assign mult_src = (state_ff == ST_ENCODE) ? scan_ff : word_ff;
   assign base = KW'(mult_src) * KW'(WORD_BITS);
   assign kval = base + KW'(zpos);
   assign onehot = WORD_BITS'(1) << pos_ff;

   always_comb begin
      if (KW'(csr_write_data) > KW'(MAX_BITS)) begin
         live_in = CNT_W'(MAX_BITS);
      end else begin
         live_in = CNT_W'(csr_write_data);
      end
   end

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      idx_in = idx_ff;
      word_in = word_ff;
      pos_in = pos_ff;
      scan_in = scan_ff;
      clr_rsp_in = clr_rsp_ff;
      hit_word_in = hit_word_ff;
      rd_en = 1'b0;
      rd_addr = word_ff;
      wr_en = 1'b0;
      wr_addr = scan_ff;
      wr_data = '0;
      rsp_valid_in = 1'b0;
      rsp_bit_value_in = 1'b0;
      rsp_found_in = '0;
      rsp_status_in = STAT_OK;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = scan_ff;
            if (scan_ff == AW'(NUM_WORDS - 1)) begin
               state_in = ST_IDLE;
               rsp_valid_in = clr_rsp_ff;
               clr_rsp_in = 1'b0;
            end else begin
               scan_in = scan_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (start) begin
               op_in = req_op;
               idx_in = req_bit_index;
               word_in = AW'(qprod >> SHIFT);
               unique case (req_op)
                  OP_READ, OP_SET, OP_CLEAR: begin
                     if (in_range) begin
                        state_in = ST_ISSUE;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_status_in = STAT_RANGE;
                     end
                  end
                  OP_CLEAR_ALL: begin
                     state_in = ST_CLEAR;
                     scan_in = '0;
                     clr_rsp_in = 1'b1;
                  end
                  OP_FIND: begin
                     state_in = ST_SCAN;
                     rd_en = 1'b1;
                     rd_addr = '0;
                     scan_in = '0;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_ISSUE: begin
            rd_en = 1'b1;
            rd_addr = word_ff;
            pos_in = PW'(KW'(idx_ff) - base);
            state_in = ST_MODIFY;
         end
         ST_MODIFY: begin
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
            wr_addr = word_ff;
            priority if (op_ff == OP_SET) begin
               wr_en = 1'b1;
               wr_data = rd_data | onehot;
            end else if (op_ff == OP_CLEAR) begin
               wr_en = 1'b1;
               wr_data = rd_data & ~onehot;
            end else begin
               rsp_bit_value_in = rd_data[pos_ff];
            end
         end
         ST_SCAN: begin
            if (rd_data != '1) begin
               hit_word_in = rd_data;
               state_in = ST_ENCODE;
            end else if (scan_ff == AW'(NUM_WORDS - 1)) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = STAT_NONE;
               state_in = ST_IDLE;
            end else begin
               rd_en = 1'b1;
               rd_addr = scan_ff + AW'(1);
               scan_in = scan_ff + AW'(1);
            end
         end
         ST_ENCODE: begin
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
            if (kval < KW'(live_ff)) begin
               rsp_found_in = kval[FI_W-1:0];
            end else begin
               rsp_status_in = STAT_NONE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         scan_ff <= '0;
         clr_rsp_ff <= 1'b0;
         live_ff <= CNT_W'(RESET_LIVE);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         scan_ff <= scan_in;
         clr_rsp_ff <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            live_ff <= live_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      idx_ff <= idx_in;
      word_ff <= word_in;
      pos_ff <= pos_in;
      hit_word_ff <= hit_word_in;
      rsp_bit_value_ff <= rsp_bit_value_in;
      rsp_found_ff <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_bit_value = rsp_bit_value_ff;
   assign rsp_found_index = rsp_found_ff;
   assign rsp_status = rsp_status_ff;

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_strobe)
      else $error("accepted request neither started work nor responded");

   a_write_state: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> state_ff == ST_MODIFY || state_ff == ST_CLEAR)
      else $error("map write outside modify or clear");

   a_fail_value: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != STAT_OK |-> !rsp_bit_value && rsp_found_index == '0)
      else $error("failed request carries data");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> KW'(scan_ff) < KW'(NUM_WORDS))
      else $error("scan address past map");

endmodule

// File: bench/tb_top.sv
// Self-checking bench for the find-first-clear bit map allocator.
`timescale 1ns / 1ps

module tb_top;
   import bfc_pkg::*;

   localparam int MAP_BITS = 1024;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [IDX_W-1:0] bit_index;
   } request_t;

   typedef struct packed {
      logic            bit_value;
      logic [FI_W-1:0] found_index;
      logic [ST_W-1:0] status;
   } answer_t;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic [OP_W-1:0]  req_op = OP_READ;
   logic [IDX_W-1:0] req_bit_index = '0;
   logic             rsp_strobe;
   logic             rsp_bit_value;
   logic [FI_W-1:0]  rsp_found_index;
   logic [ST_W-1:0]  rsp_status;
   logic             csr_write_enable = 1'b0;
   logic [BIU_W-1:0] csr_write_data = '0;

   request_t         request_queue[$];
   answer_t          due_answers[$];
   logic [MAP_BITS-1:0] shadow_map = '0;
   logic [BIU_W-1:0] shadow_count = BIU_W'(BIU_RESET);
   logic             req_taken = 1'b0;
   int               idle_pct = 0;
   int               fail_count = 0;
   int               request_count = 0;
   int               find_count = 0;
   int               none_free_count = 0;
   int               range_count = 0;
   int               count_settings = 0;

   bitmap_allocator_find_first_clear_unit uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_bit_index    (req_bit_index),
      .rsp_strobe       (rsp_strobe),
      .rsp_bit_value    (rsp_bit_value),
      .rsp_found_index  (rsp_found_index),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #2 clock = ~clock;

   function automatic answer_t predict_answer(input logic [OP_W-1:0] op,
                                              input logic [IDX_W-1:0] idx);
      answer_t ans;
      int      limit;
      logic    hit;
      ans = '0;
      limit = (int'(shadow_count) > MAP_BITS) ? MAP_BITS : int'(shadow_count);
      case (op)
         OP_READ: begin
            if (idx >= limit) ans.status = STAT_RANGE;
            else ans.bit_value = shadow_map[idx];
         end
         OP_SET: begin
            if (idx >= limit) ans.status = STAT_RANGE;
            else shadow_map[idx] = 1'b1;
         end
         OP_CLEAR: begin
            if (idx >= limit) ans.status = STAT_RANGE;
            else shadow_map[idx] = 1'b0;
         end
         OP_CLEAR_ALL: begin
            shadow_map = '0;
         end
         OP_FIND: begin
            hit = 1'b0;
            for (int k = 0; k < limit; k++) begin
               if (!hit && !shadow_map[k]) begin
                  ans.found_index = FI_W'(k);
                  hit = 1'b1;
               end
            end
            if (!hit) ans.status = STAT_NONE;
         end
         default: ;
      endcase
      return ans;
   endfunction

   // request driver
   always @(negedge clock) begin
      logic     go;
      request_t item;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         go = (request_queue.size() > 0) && ($urandom_range(99) >= idle_pct);
         if (go) begin
            item = request_queue.pop_front();
            req_op <= item.op;
            req_bit_index <= item.bit_index;
         end
         start <= go;
      end
   end

   // result monitor and predictor
   always @(posedge clock) begin
      answer_t want;
      answer_t got;
      if (reset) begin
         shadow_map = '0;
         shadow_count = BIU_W'(BIU_RESET);
         req_taken = 1'b0;
      end else begin
         if (csr_write_enable) shadow_count = csr_write_data;
         if (rsp_strobe) begin
            got = '{rsp_bit_value, rsp_found_index, rsp_status};
            if (due_answers.size() == 0) begin
               $display("%0t: unexpected result bit_value %0d found_index %0d status %0d",
                        $time, got.bit_value, got.found_index, got.status);
               fail_count++;
            end else begin
               want = due_answers.pop_front();
               if (got.bit_value !== want.bit_value) begin
                  $display("%0t: bit_value expected %0d actual %0d",
                           $time, want.bit_value, got.bit_value);
                  fail_count++;
               end
               if (got.found_index !== want.found_index) begin
                  $display("%0t: found_index expected %0d actual %0d",
                           $time, want.found_index, got.found_index);
                  fail_count++;
               end
               if (got.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, got.status);
                  fail_count++;
               end
               if (want.status == STAT_NONE) none_free_count++;
               if (want.status == STAT_RANGE) range_count++;
            end
         end
         req_taken = start && !busy;
         if (req_taken) begin
            due_answers.push_back(predict_answer(req_op, req_bit_index));
            request_count++;
            if (req_op == OP_FIND) find_count++;
         end
      end
   end

   task automatic queue_request(input logic [OP_W-1:0] op, input int idx);
      request_queue.push_back('{op, idx[IDX_W-1:0]});
   endtask

   task automatic drain();
      while (request_queue.size() != 0 || start || due_answers.size() != 0 || busy)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_count(input int value, input int pct);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data <= value[BIU_W-1:0];
      @(negedge clock);
      csr_write_enable <= 1'b0;
      idle_pct = pct;
      count_settings++;
   endtask

   task automatic queue_random(input int n, input int span);
      int made;
      int pick;
      int base;
      int len;
      int idx;
      made = 0;
      while (made < n) begin
         pick = $urandom_range(99);
         if (pick < 15 && span > 0) begin
            // run of sets from a word boundary, with a find after each eighth bit
            base = $urandom_range(span - 1) & ~31;
            len = $urandom_range(96, 32);
            for (int k = base; k < base + len && k < MAP_BITS && made < n; k++) begin
               queue_request(OP_SET, k);
               made++;
               if (k % 8 == 7) begin
                  queue_request(OP_FIND, $urandom_range(MAP_BITS - 1));
                  made++;
               end
            end
         end else begin
            if (span > 0 && $urandom_range(9) < 8) idx = $urandom_range(span - 1);
            else idx = $urandom_range(MAP_BITS - 1);
            pick = $urandom_range(99);
            if (pick < 35) queue_request(OP_SET, idx);
            else if (pick < 55) queue_request(OP_FIND, idx);
            else if (pick < 70) queue_request(OP_CLEAR, idx);
            else if (pick < 86) queue_request(OP_READ, idx);
            else if (pick < 89) queue_request(OP_CLEAR_ALL, idx);
            else queue_request(OP_W'($urandom_range(7, 5)), idx);
            made++;
         end
      end
   endtask

   initial begin
      int span;
      int spot;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_count(BIU_RESET, 0);
      queue_request(OP_FIND, 0);
      queue_request(OP_READ, 0);
      queue_request(OP_SET, 0);
      queue_request(OP_READ, 0);
      queue_request(OP_FIND, 1023);
      queue_request(OP_SET, 1023);
      queue_request(OP_READ, 1023);
      queue_request(OP_SET, 31);
      queue_request(OP_SET, 32);
      queue_request(OP_CLEAR, 0);
      queue_request(OP_FIND, 0);
      queue_request(3'd5, 1023);
      queue_request(3'd6, 0);
      queue_request(3'd7, 682);
      queue_request(3'd5, 341);
      queue_request(OP_CLEAR_ALL, 1023);
      queue_request(OP_READ, 1023);
      queue_request(OP_FIND, 0);

      write_count(5, 0);
      queue_request(OP_READ, 5);
      queue_request(OP_SET, 9);
      queue_request(OP_CLEAR, 1023);
      queue_request(OP_SET, 4);
      queue_request(OP_READ, 4);
      queue_request(OP_FIND, 0);

      // fill the whole map in order, then probe the full and nearly full cases
      write_count(MAP_BITS, 37);
      queue_request(OP_CLEAR_ALL, 0);
      for (int k = 0; k < MAP_BITS; k++) begin
         queue_request(OP_SET, k);
         if (k % 64 == 63) queue_request(OP_FIND, k);
      end
      queue_request(OP_FIND, 0);
      spot = $urandom_range(MAP_BITS - 1);
      queue_request(OP_CLEAR, spot);
      queue_request(OP_FIND, 0);
      queue_request(OP_READ, spot);
      queue_request(OP_CLEAR, MAP_BITS - 1);
      queue_request(OP_FIND, 0);
      queue_request(OP_SET, spot);
      queue_request(OP_FIND, 0);
      queue_request(OP_CLEAR_ALL, 0);
      queue_request(OP_FIND, 0);

      write_count(40, 81);
      queue_random(150, 40);

      write_count(2047, 0);
      queue_random(150, MAP_BITS);

      write_count(0, 37);
      queue_random(40, 0);

      write_count(1, 81);
      queue_random(40, 1);

      span = $urandom_range(1023, 2);
      write_count(span, 0);
      queue_random(150, span);

      write_count(1023, 81);
      queue_random(100, 1023);

      drain();
      repeat (40) @(negedge clock);
      $display("Run covered %0d requests over %0d bit-count settings:", request_count,
               count_settings);
      $display("  %0d finds, %0d with no clear bit, %0d out-of-range answers",
               find_count, none_free_count, range_count);
      if (fail_count == 0 && due_answers.size() == 0) begin
         $display("** bitmap_allocator_find_first_clear_unit: PASSED **");
      end else begin
         $display("** bitmap_allocator_find_first_clear_unit: FAILED **");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("%0t: timeout with %0d results outstanding", $time, due_answers.size());
      $display("** bitmap_allocator_find_first_clear_unit: FAILED **");
      $finish;
   end

endmodule
